/* src/spba_pkg.sv */
// Shared types, codes and constants of the source port bitmap allocator.
// Used by every module of the block; depends on nothing.
package spba_pkg;

   localparam int NUM_TABLES_DEFAULT    = 2;
   localparam int NUM_PROTOCOLS_DEFAULT = 4;
   localparam int PORT_BITS_DEFAULT     = 16;

   localparam int FIELD_PORT_BITS = 16;
   localparam int MAP_IDX_BITS    = 7;
   localparam int SLOT_BITS       = 3;
   localparam int WORD_BITS       = 64;
   localparam int BIT_IDX_BITS    = 6;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLES_READY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR_PORT   = 2'd1;

   localparam logic [1:0]  TABLES_READY_RESET = 2'b01;
   localparam logic [15:0] FLOOR_PORT_RESET   = 16'd49152;

   localparam logic [7:0] PROTO_NUM_TCP   = 8'd6;
   localparam logic [7:0] PROTO_NUM_UDP   = 8'd17;
   localparam logic [7:0] PROTO_NUM_ICMP  = 8'd1;
   localparam logic [7:0] PROTO_NUM_ICMP6 = 8'd58;

   localparam logic [SLOT_BITS-1:0] SLOT_TCP   = 3'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_UDP   = 3'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_ICMP  = 3'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_ICMP6 = 3'd3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_NO_ALLOC  = 2'd2;

   typedef struct packed {
      logic        command;
      logic        table_index;
      logic [7:0]  protocol;
      logic [15:0] requested_port;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_port;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                       is_free;
      logic                       no_alloc;
      logic [MAP_IDX_BITS-1:0]    map_idx;
      logic [FIELD_PORT_BITS-1:0] port;
   } cmd_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
   } slot_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOOK
   } back_state_type;

   function automatic slot_type proto_slot(input logic [7:0] protocol);
      slot_type s;
      s.hit  = 1'b1;
      s.slot = SLOT_TCP;
      unique case (protocol)
         PROTO_NUM_TCP:   s.slot = SLOT_TCP;
         PROTO_NUM_UDP:   s.slot = SLOT_UDP;
         PROTO_NUM_ICMP:  s.slot = SLOT_ICMP;
         PROTO_NUM_ICMP6: s.slot = SLOT_ICMP6;
         default:         s.hit  = 1'b0;
      endcase
      return s;
   endfunction

endpackage

/* src/source_port_bitmap_allocator_core.sv */
// A start beat is queued; the back end pops it, reads the first bitmap word checked (FETCH)
// and looks for a free port (LOOK), going back to FETCH for each further 64-port word searched.
// The back end takes no new command until the last one has its result; the single-port bitmap
// memory, read a word per search step, sets the pace. A 2-entry command queue keeps the request side taking beats.
// Reset: synchronous; busy stays high while the clearing pass zeroes the bitmaps.
// Results are strobed and cannot be stalled.
module source_port_bitmap_allocator_core #(
   parameter int NUM_TABLES    = spba_pkg::NUM_TABLES_DEFAULT,
   parameter int NUM_PROTOCOLS = spba_pkg::NUM_PROTOCOLS_DEFAULT,
   parameter int PORT_BITS     = spba_pkg::PORT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  spba_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   output spba_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spba_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spba_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import spba_pkg::*;

   logic [1:0]  tables_ready_ff, tables_ready_in;
   logic [15:0] floor_port_ff, floor_port_in;

   logic    push;
   logic    pop;
   logic    queue_empty;
   logic    queue_full;
   logic    clearing;
   cmd_type push_entry;
   cmd_type head;

   assign csr_ready = 1'b1;

   always_comb begin
      tables_ready_in = tables_ready_ff;
      floor_port_in   = floor_port_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TABLES_READY: tables_ready_in = csr_wdata[1:0];
            CSR_FLOOR_PORT:   floor_port_in   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tables_ready_ff <= TABLES_READY_RESET;
         floor_port_ff   <= FLOOR_PORT_RESET;
      end else begin
         tables_ready_ff <= tables_ready_in;
         floor_port_ff   <= floor_port_in;
      end
   end

   spba_front #(
      .NUM_TABLES    (NUM_TABLES),
      .NUM_PROTOCOLS (NUM_PROTOCOLS),
      .PORT_BITS     (PORT_BITS)
   ) u_front (
      .start        (start),
      .req_payload  (req_payload),
      .queue_full   (queue_full),
      .clearing     (clearing),
      .tables_ready (tables_ready_ff),
      .floor_port   (floor_port_ff[PORT_BITS-1:0]),
      .busy         (busy),
      .push         (push),
      .push_entry   (push_entry)
   );

   spba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   spba_back #(
      .NUM_TABLES    (NUM_TABLES),
      .NUM_PROTOCOLS (NUM_PROTOCOLS),
      .PORT_BITS     (PORT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .floor_port  (floor_port_ff[PORT_BITS-1:0]),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/spba_queue.sv */
// Short command queue between the classifying front and the bitmap back end.
// Depends on spba_pkg for the command entry type and depth.
module spba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spba_pkg::cmd_type push_entry,
   input  logic              pop,
   output spba_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import spba_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/spba_front.sv */
// Request front end: accepts commands, checks table and protocol, picks the start port.
// Depends on spba_pkg for request and command types and protocol codes.
module spba_front #(
   parameter int NUM_TABLES    = spba_pkg::NUM_TABLES_DEFAULT,
   parameter int NUM_PROTOCOLS = spba_pkg::NUM_PROTOCOLS_DEFAULT,
   parameter int PORT_BITS     = spba_pkg::PORT_BITS_DEFAULT
) (
   input  logic                 start,
   input  spba_pkg::req_type    req_payload,
   input  logic                 queue_full,
   input  logic                 clearing,
   input  logic [1:0]           tables_ready,
   input  logic [PORT_BITS-1:0] floor_port,
   output logic                 busy,
   output logic                 push,
   output spba_pkg::cmd_type    push_entry
);
   import spba_pkg::*;

   logic [PORT_BITS-1:0] port_masked;
   logic [PORT_BITS-1:0] start_port;
   logic                 table_ok;
   logic                 slot_ok;
   slot_type             slot_info;

   assign busy = clearing || queue_full;
   assign push = start && !busy;

   assign port_masked = req_payload.requested_port[PORT_BITS-1:0];
   assign start_port  = (req_payload.command == CMD_ALLOC && port_masked == '0)
                        ? floor_port : port_masked;

   assign slot_info = proto_slot(req_payload.protocol);
   assign slot_ok   = slot_info.hit && (int'(slot_info.slot) < NUM_PROTOCOLS);
   assign table_ok  = (NUM_TABLES > 1 || req_payload.table_index == 1'b0)
                      && tables_ready[req_payload.table_index];

   always_comb begin
      push_entry.is_free  = (req_payload.command == CMD_FREE);
      push_entry.no_alloc = !(table_ok && slot_ok);
      push_entry.map_idx  = MAP_IDX_BITS'(req_payload.table_index)
                            * MAP_IDX_BITS'(NUM_PROTOCOLS)
                            + MAP_IDX_BITS'(slot_info.slot);
      push_entry.port     = FIELD_PORT_BITS'(start_port);
   end

endmodule

/* src/spba_back.sv */
// Back end: bitmap memory with clearing pass, word-at-a-time free-port search and port release.
// Depends on spba_pkg for command, result and state types.
module spba_back #(
   parameter int NUM_TABLES    = spba_pkg::NUM_TABLES_DEFAULT,
   parameter int NUM_PROTOCOLS = spba_pkg::NUM_PROTOCOLS_DEFAULT,
   parameter int PORT_BITS     = spba_pkg::PORT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spba_pkg::cmd_type    head,
   input  logic                 queue_empty,
   input  logic [PORT_BITS-1:0] floor_port,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output spba_pkg::rsp_type    rsp_payload
);
   import spba_pkg::*;

   localparam int NUM_MAPS      = NUM_TABLES * NUM_PROTOCOLS;
   localparam int WORD_IDX_BITS = PORT_BITS - BIT_IDX_BITS;
   localparam int WORDS         = 1 << WORD_IDX_BITS;
   localparam int DEPTH         = NUM_MAPS * WORDS;
   localparam int ADDR_BITS     = $clog2(DEPTH);
   localparam int MAP_BITS      = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
   localparam logic [PORT_BITS-1:0] TOP_PORT  = {PORT_BITS{1'b1}};
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   function automatic logic [BIT_IDX_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0]    w;
      logic [BIT_IDX_BITS-1:0] idx;
      w   = v;
      idx = '0;
      for (int l = BIT_IDX_BITS - 1; l >= 0; l--) begin
         if ((w & ((WORD_BITS'(1) << (1 << l)) - WORD_BITS'(1))) == '0) begin
            idx[l] = 1'b1;
            w      = w >> (1 << l);
         end
      end
      return idx;
   endfunction

   logic [WORD_BITS-1:0] mem [DEPTH];

   back_state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0]      clr_ff, clr_in;
   logic                      is_free_ff, is_free_in;
   logic                      wrap_ff, wrap_in;
   logic [MAP_BITS-1:0]       map_ff, map_in;
   logic [PORT_BITS-1:0]      req_port_ff, req_port_in;
   logic [WORD_IDX_BITS-1:0]  word_ff, word_in;
   logic [BIT_IDX_BITS-1:0]   bit_ff, bit_in;
   logic [WORD_BITS-1:0]      rdata_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      mem_we;
   logic                      mem_re;
   logic [ADDR_BITS-1:0]      mem_addr;
   logic [ADDR_BITS-1:0]      cur_addr;
   logic [WORD_BITS-1:0]      mem_wdata;

   logic [WORD_BITS-1:0]      free_bits;
   logic                      any_free;
   logic [BIT_IDX_BITS-1:0]   found_idx;
   logic [PORT_BITS-1:0]      found_port;
   logic                      found_ok;
   logic                      last_word;
   logic                      advance;
   logic                      wrap_go;

   assign clearing    = (state_ff == ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cur_addr   = (ADDR_BITS'(map_ff) << WORD_IDX_BITS) | ADDR_BITS'(word_ff);
   assign free_bits  = ~rdata_ff & ({WORD_BITS{1'b1}} << bit_ff);
   assign any_free   = |free_bits;
   assign found_idx  = lowest_set(free_bits);
   assign found_port = {word_ff, found_idx};
   assign found_ok   = any_free && (found_port != TOP_PORT || req_port_ff == TOP_PORT);
   assign last_word  = (word_ff == {WORD_IDX_BITS{1'b1}});
   assign advance    = !any_free && !last_word;
   assign wrap_go    = !advance && !wrap_ff && (floor_port != TOP_PORT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!queue_empty && !head.no_alloc) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (!is_free_ff && !found_ok && (advance || wrap_go)) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = cur_addr;
      mem_wdata    = rdata_ff;
      clr_in       = clr_ff;
      is_free_in   = is_free_ff;
      wrap_in      = wrap_ff;
      map_in       = map_ff;
      req_port_in  = req_port_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head.no_alloc) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_NO_ALLOC;
               end else begin
                  is_free_in  = head.is_free;
                  wrap_in     = 1'b0;
                  map_in      = head.map_idx[MAP_BITS-1:0];
                  req_port_in = head.port[PORT_BITS-1:0];
                  word_in     = head.port[PORT_BITS-1:BIT_IDX_BITS];
                  bit_in      = head.port[BIT_IDX_BITS-1:0];
               end
            end
         end
         ST_FETCH: begin
            mem_re = 1'b1;
         end
         ST_LOOK: begin
            if (is_free_ff) begin
               mem_we        = 1'b1;
               mem_wdata     = rdata_ff & ~(WORD_BITS'(1) << bit_ff);
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_OK;
            end else if (found_ok) begin
               mem_we              = 1'b1;
               mem_wdata           = rdata_ff | (WORD_BITS'(1) << found_idx);
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.granted_port = FIELD_PORT_BITS'(found_port);
            end else if (advance) begin
               word_in = word_ff + 1'b1;
               bit_in  = '0;
            end else if (wrap_go) begin
               wrap_in = 1'b1;
               word_in = floor_port[PORT_BITS-1:BIT_IDX_BITS];
               bit_in  = floor_port[BIT_IDX_BITS-1:0];
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_EXHAUSTED;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff  <= is_free_in;
      wrap_ff     <= wrap_in;
      map_ff      <= map_in;
      req_port_ff <= req_port_in;
      word_ff     <= word_in;
      bit_ff      <= bit_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

endmodule
